>>> hdl/aes128_reduced_round_encrypt_macros.svh
// assertion macros used by the block's top module
`ifndef AES128_REDUCED_ROUND_ENCRYPT_MACROS_SVH
`define AES128_REDUCED_ROUND_ENCRYPT_MACROS_SVH
// a condition implies another in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// a condition implies another in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

>>> hdl/aes128rr_pkg.sv
package aes128rr_pkg;
	localparam int MAX_ROUNDS_DEF = 10;
	localparam logic [3:0] REG_KEY_HIGH = 4'd0;
	localparam logic [3:0] REG_KEY_LOW = 4'd1;
	localparam logic [3:0] REG_ROUND_COUNT = 4'd2;
	localparam logic [3:0] REG_LAST_MIX = 4'd3;
	localparam logic [7:0] GF_POLY = 8'h1b;

	typedef logic [127:0] blk_t;

	// control that travels with each block down the round pipeline
	typedef struct packed {
		logic       vld;
		logic [3:0] rounds;
		logic       last_mix;
	} ctl_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] gf_double(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

	// byte i of a block, byte 0 in the top bits
	function automatic logic [7:0] byte_at(input blk_t b, input int i);
		return b[127 - 8*i -: 8];
	endfunction

	// one key schedule step
	function automatic blk_t expand_key(input blk_t k, input logic [7:0] rcon);
		blk_t n;
		logic [31:0] w;
		w = {sbox(byte_at(k, 13)) ^ rcon, sbox(byte_at(k, 14)), sbox(byte_at(k, 15)),
			sbox(byte_at(k, 12))};
		n[127:96] = k[127:96] ^ w;
		n[95:64] = k[95:64] ^ n[127:96];
		n[63:32] = k[63:32] ^ n[95:64];
		n[31:0] = k[31:0] ^ n[63:32];
		return n;
	endfunction
endpackage

>>> hdl/aes128rr_column.sv
// one column lane: sub bytes on shifted bytes, optional mix, key add
module aes128rr_column import aes128rr_pkg::*; (
	input  logic [31:0] col_in,
	input  logic        mix,
	input  logic [31:0] rkey,
	output logic [31:0] col_out
);
	logic [7:0] a0, a1, a2, a3, all;
	logic [31:0] m;

	// substitution of the four bytes gathered by the row shift
	assign a0 = sbox(col_in[31:24]);
	assign a1 = sbox(col_in[23:16]);
	assign a2 = sbox(col_in[15:8]);
	assign a3 = sbox(col_in[7:0]);
	assign all = a0 ^ a1 ^ a2 ^ a3;

	// column mix and key add
	always_comb begin
		m = {a0 ^ all ^ gf_double(a0 ^ a1), a1 ^ all ^ gf_double(a1 ^ a2),
			a2 ^ all ^ gf_double(a2 ^ a3), a3 ^ all ^ gf_double(a3 ^ a0)};
		col_out = (mix ? m : {a0, a1, a2, a3}) ^ rkey;
	end
endmodule

>>> hdl/aes128rr_round.sv
// one round stage: four column lanes, merged into the next state register
module aes128rr_round import aes128rr_pkg::*; #(
	parameter int RND = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  blk_t st_in,
	input  blk_t key_in,
	input  logic [7:0] rcon_in,
	input  ctl_t ctl_in,
	output blk_t st_q,
	output blk_t key_q,
	output logic [7:0] rcon_q,
	output ctl_t ctl_q
);
	blk_t rk, nst;
	logic active, mix;

	assign rk = expand_key(key_in, rcon_in);
	assign active = RND <= int'(ctl_in.rounds);
	assign mix = (RND < int'(ctl_in.rounds)) || ctl_in.last_mix;

	// column lanes, each taking the row-shifted bytes
	for (genvar c = 0; c < 4; c++) begin : g_col
		logic [31:0] ci;
		assign ci = {byte_at(st_in, 4*c), byte_at(st_in, 4*((c+1)%4) + 1),
			byte_at(st_in, 4*((c+2)%4) + 2), byte_at(st_in, 4*((c+3)%4) + 3)};
		aes128rr_column u_col (.col_in(ci), .mix(mix), .rkey(rk[127-32*c -: 32]),
			.col_out(nst[127-32*c -: 32]));
	end

	// control register of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	// stage register, past the configured count the block passes unchanged
	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= active ? nst : st_in;
			key_q <= rk;
			rcon_q <= gf_double(rcon_in);
		end
	end
endmodule

>>> hdl/aes128_reduced_round_encrypt.sv
// Fully unrolled AES-128 encryptor with a configurable round count: one
// block is taken every cycle while not stalled and passes through one key-add
// stage plus one stage per round, each round built from four column lanes;
// the whole pipeline stalls while m_tvalid is high and m_tready is low.
// Rounds beyond round_count pass the block through unchanged.
module aes128_reduced_round_encrypt import aes128rr_pkg::*; #(
	parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // block_low, block_high
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // cipher_low, cipher_high
	input  logic         cfg_we,
	input  logic [3:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	`include "aes128_reduced_round_encrypt_macros.svh"

	logic [63:0] key_high_q, key_low_q;
	logic [3:0] rcount_q, rsat;
	logic last_mix_q, en;
	blk_t st [MAX_ROUNDS+1];
	blk_t ky [MAX_ROUNDS+1];
	logic [7:0] rc [MAX_ROUNDS+1];
	ctl_t ct [MAX_ROUNDS+1];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			rcount_q <= 4'd10;
			last_mix_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW: key_low_q <= cfg_data;
				REG_ROUND_COUNT: rcount_q <= cfg_data[3:0];
				REG_LAST_MIX: last_mix_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign rsat = (rcount_q == 4'd0) ? 4'd1 :
		(int'(rcount_q) > MAX_ROUNDS) ? 4'(MAX_ROUNDS) : rcount_q;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// initial key add stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ct[0] <= '0;
		end else if (en) begin
			ct[0].vld <= s_tvalid;
			ct[0].rounds <= rsat;
			ct[0].last_mix <= last_mix_q;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			st[0] <= {s_tdata[63:0], s_tdata[127:64]} ^ {key_high_q, key_low_q};
			ky[0] <= {key_high_q, key_low_q};
			rc[0] <= 8'h01;
		end
	end

	// round stages
	for (genvar r = 1; r <= MAX_ROUNDS; r++) begin : g_rnd
		aes128rr_round #(.RND(r)) u_rnd (.clk(clk), .arst_n(arst_n), .en(en),
			.st_in(st[r-1]), .key_in(ky[r-1]), .rcon_in(rc[r-1]), .ctl_in(ct[r-1]),
			.st_q(st[r]), .key_q(ky[r]), .rcon_q(rc[r]), .ctl_q(ct[r]));
	end

	assign m_tvalid = ct[MAX_ROUNDS].vld;
	assign m_tdata = {st[MAX_ROUNDS][63:0], st[MAX_ROUNDS][127:64]};

	`ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`ASSERT_IMPL(a_ready_free, clk, arst_n, !m_tvalid, s_tready)
	`ASSERT_NEXT(a_enter, clk, arst_n, s_tvalid && s_tready, ct[0].vld)
endmodule

>>> tb/tb.sv
module tb;
	import aes128rr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LAT = MAX_ROUNDS_DEF + 1;
	localparam int LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// predictor copy of the configuration
	logic [63:0] key_hi_q, key_lo_q;
	logic [3:0] rounds_q;
	logic last_mix_q;

	logic [127:0] cipher_q[$];
	int send_idle_pct, recv_stall_pct;
	bit hold_off;
	int errors;
	longint cycles;

	aes128_reduced_round_encrypt u_top (.*);

	always #4 clk = ~clk;

	// forward s-box built by inversion and affine map, independent of the package
	logic [7:0] sub_tab [256];
	function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		p = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction
	initial begin
		logic [7:0] inv, x, s;
		for (int v = 0; v < 256; v++) begin
			inv = 0;
			for (int c = 1; c < 256; c++)
				if (gmul(v[7:0], c[7:0]) == 8'h01) inv = c[7:0];
			x = inv;
			s = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
				^ {x[3:0], x[7:4]} ^ 8'h63;
			sub_tab[v] = s;
		end
	end

	function automatic logic [7:0] xtime(logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// ciphertext for one block under the current configuration
	function automatic logic [127:0] encrypt(logic [127:0] pt);
		logic [7:0] st[16], ky[16], t[16], rc, a0, a1, a2, a3, al;
		logic [7:0] w0, w1, w2, w3;
		int n;
		logic mix;
		n = rounds_q == 0 ? 1 : (rounds_q > 10 ? 10 : rounds_q);
		for (int i = 0; i < 8; i++) begin
			st[i] = pt[127 - 8*i -: 8];
			st[i+8] = pt[63 - 8*i -: 8];
			ky[i] = key_hi_q[63 - 8*i -: 8];
			ky[i+8] = key_lo_q[63 - 8*i -: 8];
		end
		for (int i = 0; i < 16; i++) st[i] ^= ky[i];
		rc = 8'h01;
		for (int r = 1; r <= n; r++) begin
			w0 = sub_tab[ky[13]] ^ rc; w1 = sub_tab[ky[14]];
			w2 = sub_tab[ky[15]]; w3 = sub_tab[ky[12]];
			ky[0] ^= w0; ky[1] ^= w1; ky[2] ^= w2; ky[3] ^= w3;
			for (int i = 4; i < 16; i++) ky[i] ^= ky[i-4];
			rc = xtime(rc);
			mix = (r < n) || last_mix_q;
			for (int c = 0; c < 4; c++)
				for (int q = 0; q < 4; q++)
					t[c*4+q] = sub_tab[st[((c+q) % 4)*4 + q]];
			if (mix)
				for (int c = 0; c < 4; c++) begin
					a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
					al = a0 ^ a1 ^ a2 ^ a3;
					t[c*4] = a0 ^ al ^ xtime(a0 ^ a1);
					t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
					t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
					t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
				end
			for (int i = 0; i < 16; i++) st[i] = t[i] ^ ky[i];
		end
		for (int i = 0; i < 16; i++) encrypt[127 - 8*i -: 8] = st[i];
	endfunction

	// receiver: random stall, long hold-off on request
	always @(negedge clk) begin
		if (hold_off) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result checker, cipher_high in the low half of tdata
	always @(posedge clk) begin
		logic [127:0] exp_c;
		if (arst_n && m_tvalid && m_tready) begin
			if (cipher_q.size() == 0) begin
				$error("unexpected result %h", m_tdata);
				errors++;
			end else begin
				exp_c = cipher_q.pop_front();
				if (m_tdata[63:0] !== exp_c[127:64]) begin
					$error("cipher_high expected %h actual %h", exp_c[127:64], m_tdata[63:0]);
					errors++;
				end
				if (m_tdata[127:64] !== exp_c[63:0]) begin
					$error("cipher_low expected %h actual %h", exp_c[63:0], m_tdata[127:64]);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [3:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KEY_HIGH: key_hi_q = val;
			REG_KEY_LOW: key_lo_q = val;
			REG_ROUND_COUNT: rounds_q = val[3:0];
			REG_LAST_MIX: last_mix_q = val[0];
			default: ;
		endcase
	endtask

	// one block transfer, predicted at acceptance; valid stays up until the
	// next block or the next drain
	task automatic send_block(logic [127:0] pt);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1; s_tdata <= {pt[63:0], pt[127:64]};
		do @(posedge clk); while (!s_tready);
		cipher_q.push_back(encrypt(pt));
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (cipher_q.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [127:0] rand_block();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	task automatic set_config(logic [63:0] kh, logic [63:0] kl, logic [63:0] rc, logic [63:0] lm);
		drain();
		write_reg(REG_KEY_HIGH, kh);
		write_reg(REG_KEY_LOW, kl);
		write_reg(REG_ROUND_COUNT, rc);
		write_reg(REG_LAST_MIX, lm);
	endtask

	// standard vector, reset config, extremes and round count corners
	task automatic test_directed();
		send_block('0);
		send_block('1);
		set_config(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 10, 0);
		send_block(128'h3243f6a8885a308d313198a2e0370734);
		send_block('1);
		set_config('1, '1, 0, 1);
		send_block('0);
		send_block('1);
		set_config('0, '0, 1, 0);
		send_block(128'h8000_0000_0000_0000_0000_0000_0000_0001);
		set_config({$urandom, $urandom}, {$urandom, $urandom}, 15, 1);
		send_block(rand_block());
		set_config({$urandom, $urandom}, {$urandom, $urandom}, 64'hffff_ffff_ffff_fff5, 3);
		send_block(rand_block());
		drain();
		// out-of-range index must be ignored
		write_reg(4'd7, 64'hdead);
		write_reg(4'd15, '1);
		for (int r = 0; r < 16; r++) begin
			set_config(key_hi_q, key_lo_q, r, r & 1);
			send_block(rand_block());
		end
	endtask

	task automatic test_random(int n, int sidle, int rstall);
		set_config({$urandom, $urandom}, {$urandom, $urandom},
			$urandom_range(15), $urandom_range(1));
		send_idle_pct = sidle; recv_stall_pct = rstall;
		for (int i = 0; i < n; i++) send_block(rand_block());
	endtask

	// sink blocked for a long time while blocks keep coming
	task automatic test_backpressure();
		drain();
		send_idle_pct = 0; recv_stall_pct = 0;
		hold_off = 1;
		fork
			begin
				repeat (60) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 40; i++) send_block(rand_block());
		join
	endtask

	initial begin
		errors = 0; cycles = 0; hold_off = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		key_hi_q = 0; key_lo_q = 0; rounds_q = 10; last_mix_q = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(170, 0, 0);
		test_random(170, 50, 0);
		test_random(170, 0, 50);
		test_random(170, 23, 23);
		test_backpressure();
		drain();
		if (errors == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end
endmodule
